FILE: hw/rtl/rfft_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the radix-2 fft butterfly engine
package rfft_pkg;

    localparam int unsigned FFT_POINTS_DEF = 128;
    localparam int unsigned SLOTS          = 128;
    localparam int unsigned TW_DEPTH       = 127;
    localparam int unsigned STAGES         = 7;
    localparam int unsigned SLOT_W         = 7;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned TW_W           = 18;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned BASE_W         = 7;

    typedef enum logic [1:0] {
        OP_WR_SAMPLE  = 2'd0,
        OP_WR_TWIDDLE = 2'd1,
        OP_RUN        = 2'd2,
        OP_RD_POINT   = 2'd3
    } t_op;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDOUT,
        S_RD,
        S_MUL,
        S_ADD,
        S_WRE,
        S_WRO,
        S_DONE
    } t_state;

    typedef logic [BASE_W-1:0] t_base_arr [STAGES];

    localparam t_base_arr BASE_RESET = '{7'd0, 7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63};

    // butterfly datapath strobes
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_bfly_ctrl;

    // saturate a sample part to the q2.16 twiddle range
    function automatic logic signed [TW_W-1:0] sat_tw(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        hi = DATA_W'(131071);
        lo = -DATA_W'(131072);
        if (v > hi) begin
            return TW_W'(hi);
        end else if (v < lo) begin
            return TW_W'(lo);
        end
        return v[TW_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/rfft_in_if.sv
`timescale 1ns / 1ps
// input channel of the fft engine: operation items
interface rfft_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           operation;
    logic [rfft_pkg::SLOT_W-1:0]          slot;
    logic signed [rfft_pkg::DATA_W-1:0]   data_real;
    logic signed [rfft_pkg::DATA_W-1:0]   data_imag;

    modport source (output valid, operation, slot, data_real, data_imag, input ready);
    modport sink   (input valid, operation, slot, data_real, data_imag, output ready);
endinterface

FILE: hw/rtl/rfft_out_if.sv
`timescale 1ns / 1ps
// output channel of the fft engine: result items
interface rfft_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [rfft_pkg::SLOT_W-1:0]          point_index;
    logic signed [rfft_pkg::DATA_W-1:0]   point_real;
    logic signed [rfft_pkg::DATA_W-1:0]   point_imag;

    modport source (output valid, kind, point_index, point_real, point_imag, input ready);
    modport sink   (input valid, kind, point_index, point_real, point_imag, output ready);
endinterface

FILE: hw/rtl/rfft_bfly.sv
`timescale 1ns / 1ps
// two-step butterfly datapath: complex multiply, then round and saturating add/subtract
module rfft_bfly (
    input  logic                                 i_clk,
    input  rfft_pkg::t_bfly_ctrl                 i_ctrl,
    input  logic signed [rfft_pkg::DATA_W-1:0]   i_even_re,
    input  logic signed [rfft_pkg::DATA_W-1:0]   i_even_im,
    input  logic signed [rfft_pkg::DATA_W-1:0]   i_odd_re,
    input  logic signed [rfft_pkg::DATA_W-1:0]   i_odd_im,
    input  logic signed [rfft_pkg::TW_W-1:0]     i_w_re,
    input  logic signed [rfft_pkg::TW_W-1:0]     i_w_im,
    output logic signed [rfft_pkg::DATA_W-1:0]   o_sum_re,
    output logic signed [rfft_pkg::DATA_W-1:0]   o_sum_im,
    output logic signed [rfft_pkg::DATA_W-1:0]   o_dif_re,
    output logic signed [rfft_pkg::DATA_W-1:0]   o_dif_im
);
    localparam int unsigned DW = rfft_pkg::DATA_W;
    localparam int unsigned PW = rfft_pkg::DATA_W + rfft_pkg::TW_W;
    localparam int unsigned SW = PW + 1;
    localparam int unsigned TW = SW - 16;
    localparam int unsigned AW = TW + 1;

    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [DW-1:0] r_even_re, r_even_im;
    logic signed [DW-1:0] r_sum_re, r_sum_im, r_dif_re, r_dif_im;

    logic signed [SW-1:0] s_pr, s_pi;
    logic signed [TW-1:0] s_tr, s_ti;
    logic signed [AW-1:0] s_a_re, s_a_im, s_d_re, s_d_im;

    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'(2147483647);
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(DW-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DW-1){1'b0}}};
        end
        return v[DW-1:0];
    endfunction

    // round to nearest, ties upward: floor((p + 2^15) / 2^16)
    always_comb begin
        s_pr   = SW'(r_p_rr) - SW'(r_p_ii) + SW'(32768);
        s_pi   = SW'(r_p_ri) + SW'(r_p_ir) + SW'(32768);
        s_tr   = s_pr[SW-1:16];
        s_ti   = s_pi[SW-1:16];
        s_a_re = AW'(r_even_re) + AW'(s_tr);
        s_a_im = AW'(r_even_im) + AW'(s_ti);
        s_d_re = AW'(r_even_re) - AW'(s_tr);
        s_d_im = AW'(r_even_im) - AW'(s_ti);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p_rr    <= PW'(i_odd_re) * PW'(i_w_re);
            r_p_ii    <= PW'(i_odd_im) * PW'(i_w_im);
            r_p_ri    <= PW'(i_odd_re) * PW'(i_w_im);
            r_p_ir    <= PW'(i_odd_im) * PW'(i_w_re);
            r_even_re <= i_even_re;
            r_even_im <= i_even_im;
        end
        if (i_ctrl.add_en) begin
            r_sum_re <= sat32(s_a_re);
            r_sum_im <= sat32(s_a_im);
            r_dif_re <= sat32(s_d_re);
            r_dif_im <= sat32(s_d_im);
        end
    end

    assign o_sum_re = r_sum_re;
    assign o_sum_im = r_sum_im;
    assign o_dif_re = r_dif_re;
    assign o_dif_im = r_dif_im;
endmodule

FILE: hw/rtl/radix2_fft_butterfly_engine_top.sv
`timescale 1ns / 1ps
// top level of the in-place radix-2 fft butterfly engine
// operations: sample and twiddle writes give no result; a point read loads the sample
//   into a read register, then loads the output register once that register is free
// throughput: one write per cycle while idle; no new item is taken during a read or
//   a transform; each butterfly of a transform runs the read / multiply / add /
//   write-even / write-odd sequence on the single sample write port
// reset: i_rst_n synchronous, active low; clears the sequencer and the output valid flag
//   and loads the stage base registers with their defaults; sample and twiddle memories are not cleared
module radix2_fft_butterfly_engine_top #(
    parameter int unsigned FFT_POINTS = rfft_pkg::FFT_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rfft_in_if.sink                            i_in,
    rfft_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [rfft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfft_pkg::BASE_W-1:0]        i_cfg_data
);
    localparam int unsigned LOG_N  = $clog2(FFT_POINTS);
    localparam int unsigned K_W    = LOG_N - 1;
    localparam int unsigned ST_W   = $clog2(LOG_N);
    localparam int unsigned AW     = rfft_pkg::SLOT_W;
    localparam int unsigned DW     = rfft_pkg::DATA_W;
    localparam int unsigned TWW    = rfft_pkg::TW_W;
    localparam logic [K_W-1:0]  K_LAST  = {K_W{1'b1}};
    localparam logic [ST_W-1:0] ST_LAST = ST_W'(LOG_N - 1);
    localparam logic [AW-1:0]   TW_NONE = AW'(rfft_pkg::TW_DEPTH);

    // memories: samples as {re, im}, twiddles as {re, im} in q2.16
    logic [2*DW-1:0]  r_samp_mem [rfft_pkg::SLOTS];
    logic [2*TWW-1:0] r_tw_mem   [rfft_pkg::TW_DEPTH];

    logic [2*DW-1:0]  r_rd_a, r_rd_b;
    logic [2*TWW-1:0] r_tw_rd;
    logic             r_w_zero;

    rfft_pkg::t_state r_state, n_state;
    logic [ST_W-1:0]  r_stage, n_stage;
    logic [K_W-1:0]   r_k, n_k;
    logic [AW-1:0]    r_idx, n_idx;

    logic [rfft_pkg::BASE_W-1:0] r_base [rfft_pkg::STAGES];

    logic             r_ov;
    logic             r_kind;
    logic [AW-1:0]    r_pidx;
    logic [DW-1:0]    r_pre, r_pim;

    // combinational control
    logic             s_acc;
    logic             s_out_free;
    logic             s_rd_en_a, s_rd_en_b, s_tw_en;
    logic [AW-1:0]    s_addr_a;
    logic             s_we;
    logic [AW-1:0]    s_waddr;
    logic [2*DW-1:0]  s_wdata;
    logic             s_load_rd, s_load_done;
    rfft_pkg::t_bfly_ctrl s_bctl;

    logic [AW-1:0]    s_kx, s_off, s_e, s_o, s_wi, s_half, s_mask;
    logic [AW-1:0]    s_base;

    logic signed [DW-1:0] s_sum_re, s_sum_im, s_dif_re, s_dif_im;

    assign s_acc      = i_in.valid && i_in.ready;
    assign s_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == rfft_pkg::S_IDLE);

    // butterfly addressing: k-th butterfly of stage s
    always_comb begin
        s_kx   = AW'(r_k);
        s_half = AW'(1) << r_stage;
        s_mask = s_half - AW'(1);
        s_off  = s_kx & s_mask;
        s_e    = ((s_kx >> r_stage) << (r_stage + ST_W'(1))) | s_off;
        s_o    = s_e + s_half;
        s_base = r_base[r_stage];
        s_wi   = s_base + s_off;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        n_k         = r_k;
        n_idx       = r_idx;
        s_rd_en_a   = 1'b0;
        s_rd_en_b   = 1'b0;
        s_tw_en     = 1'b0;
        s_addr_a    = s_e;
        s_we        = 1'b0;
        s_waddr     = s_e;
        s_wdata     = {s_sum_re, s_sum_im};
        s_load_rd   = 1'b0;
        s_load_done = 1'b0;
        s_bctl      = '0;
        case (r_state)
            rfft_pkg::S_IDLE: begin
                s_addr_a = i_in.slot;
                s_waddr  = i_in.slot;
                s_wdata  = {i_in.data_real, i_in.data_imag};
                if (s_acc) begin
                    case (rfft_pkg::t_op'(i_in.operation))
                        rfft_pkg::OP_WR_SAMPLE: s_we = 1'b1;
                        rfft_pkg::OP_RUN: begin
                            n_stage = '0;
                            n_k     = '0;
                            n_state = rfft_pkg::S_RD;
                        end
                        rfft_pkg::OP_RD_POINT: begin
                            s_rd_en_a = 1'b1;
                            n_idx     = i_in.slot;
                            n_state   = rfft_pkg::S_RDOUT;
                        end
                        default: ;
                    endcase
                end
            end
            rfft_pkg::S_RDOUT: begin
                if (s_out_free) begin
                    s_load_rd = 1'b1;
                    n_state   = rfft_pkg::S_IDLE;
                end
            end
            rfft_pkg::S_RD: begin
                s_rd_en_a = 1'b1;
                s_rd_en_b = 1'b1;
                s_tw_en   = 1'b1;
                n_state   = rfft_pkg::S_MUL;
            end
            rfft_pkg::S_MUL: begin
                s_bctl.mul_en = 1'b1;
                n_state       = rfft_pkg::S_ADD;
            end
            rfft_pkg::S_ADD: begin
                s_bctl.add_en = 1'b1;
                n_state       = rfft_pkg::S_WRE;
            end
            rfft_pkg::S_WRE: begin
                s_we    = 1'b1;
                n_state = rfft_pkg::S_WRO;
            end
            rfft_pkg::S_WRO: begin
                s_we    = 1'b1;
                s_waddr = s_o;
                s_wdata = {s_dif_re, s_dif_im};
                n_state = rfft_pkg::S_RD;
                if (r_k == K_LAST) begin
                    n_k = '0;
                    if (r_stage == ST_LAST) begin
                        n_state = rfft_pkg::S_DONE;
                    end else begin
                        n_stage = r_stage + ST_W'(1);
                    end
                end else begin
                    n_k = r_k + K_W'(1);
                end
            end
            rfft_pkg::S_DONE: begin
                if (s_out_free) begin
                    s_load_done = 1'b1;
                    n_state     = rfft_pkg::S_IDLE;
                end
            end
            default: n_state = rfft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfft_pkg::S_IDLE;
            r_stage <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_k     <= n_k;
        end
        r_idx <= n_idx;
    end

    // stage base registers; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= rfft_pkg::BASE_RESET;
        end else if (i_cfg_we && (32'(i_cfg_index) < rfft_pkg::STAGES)) begin
            r_base[i_cfg_index] <= i_cfg_data;
        end
    end

    // sample memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_samp_mem[s_waddr] <= s_wdata;
        end
        if (s_rd_en_a) begin
            r_rd_a <= r_samp_mem[s_addr_a];
        end
        if (s_rd_en_b) begin
            r_rd_b <= r_samp_mem[s_o];
        end
    end

    // twiddle memory; slot 127 has no entry and reads as weight zero
    always_ff @(posedge i_clk) begin
        if (s_acc && (rfft_pkg::t_op'(i_in.operation) == rfft_pkg::OP_WR_TWIDDLE)
                && (i_in.slot != TW_NONE)) begin
            r_tw_mem[i_in.slot] <= {rfft_pkg::sat_tw(i_in.data_real),
                                    rfft_pkg::sat_tw(i_in.data_imag)};
        end
        if (s_tw_en) begin
            r_w_zero <= (s_wi == TW_NONE);
            if (s_wi != TW_NONE) begin
                r_tw_rd <= r_tw_mem[s_wi];
            end
        end
    end

    rfft_bfly u_bfly (
        .i_clk     (i_clk),
        .i_ctrl    (s_bctl),
        .i_even_re (r_rd_a[2*DW-1:DW]),
        .i_even_im (r_rd_a[DW-1:0]),
        .i_odd_re  (r_rd_b[2*DW-1:DW]),
        .i_odd_im  (r_rd_b[DW-1:0]),
        .i_w_re    (r_w_zero ? '0 : r_tw_rd[2*TWW-1:TWW]),
        .i_w_im    (r_w_zero ? '0 : r_tw_rd[TWW-1:0]),
        .o_sum_re  (s_sum_re),
        .o_sum_im  (s_sum_im),
        .o_dif_re  (s_dif_re),
        .o_dif_im  (s_dif_im)
    );

    // output register: holds one result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s_load_rd || s_load_done) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (s_load_rd) begin
            r_kind <= rfft_pkg::KIND_READ;
            r_pidx <= r_idx;
            r_pre  <= r_rd_a[2*DW-1:DW];
            r_pim  <= r_rd_a[DW-1:0];
        end else if (s_load_done) begin
            r_kind <= rfft_pkg::KIND_DONE;
            r_pidx <= '0;
            r_pre  <= '0;
            r_pim  <= '0;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.point_index = r_pidx;
    assign o_out.point_real  = r_pre;
    assign o_out.point_imag  = r_pim;
endmodule
